// ===== hw/rtl/rtch_pkg.sv =====
// ----------------------------------------------------------------------------
// rtch_pkg
// Types, widths, register map and the multiply-accumulate microcode table
// shared by the closest-hit ray/triangle unit.
// ----------------------------------------------------------------------------
package rtch_pkg;

  // field widths
  localparam int TRIANGLE_ID_BITS = 16;
  localparam int INSTANCE_ID_BITS = 8;
  localparam int COORD_W = 32;
  localparam int DIST_W  = 31;
  localparam int BARY_W  = 17;

  // datapath widths
  localparam int E_W    = 33;               // edge and offset vectors
  localparam int P_W    = 36;               // (D x E2) >> 30
  localparam int Q_W    = 51;               // (F x E1) >> 16
  localparam int QSPLIT = 25;               // q split point for the multiplier
  localparam int MUL_W  = 36;               // multiplier operand width
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 88;               // accumulator
  localparam int DET_W  = 72;               // det and nu
  localparam int CMP_W  = 104;              // accept checks
  localparam int DIV_W  = 104;              // divider remainder
  localparam int QUO_W  = 32;
  localparam int ITER_W = 6;

  // register map
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;

  localparam logic [4:0] MC_LAST = 5'd29;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_a_x;
    logic signed [COORD_W-1:0] vertex_a_y;
    logic signed [COORD_W-1:0] vertex_a_z;
    logic signed [COORD_W-1:0] vertex_b_x;
    logic signed [COORD_W-1:0] vertex_b_y;
    logic signed [COORD_W-1:0] vertex_b_z;
    logic signed [COORD_W-1:0] vertex_c_x;
    logic signed [COORD_W-1:0] vertex_c_y;
    logic signed [COORD_W-1:0] vertex_c_z;
    logic [TRIANGLE_ID_BITS-1:0] triangle_id;
    logic [INSTANCE_ID_BITS-1:0] instance_id;
    logic                        last_triangle;
  } rtch_in_t;

  typedef struct packed {
    logic                        hit;
    logic [INSTANCE_ID_BITS-1:0] hit_instance;
    logic [TRIANGLE_ID_BITS-1:0] hit_triangle;
    logic [DIST_W-1:0]           distance;
    logic [BARY_W-1:0]           bary_w;
    logic [BARY_W-1:0]           bary_u;
    logic [BARY_W-1:0]           bary_v;
  } rtch_out_t;

  // accumulate control for the shared multiplier
  typedef struct packed {
    logic sub;
    logic sh;
    logic first;
  } rtch_mac_ctl_t;

  typedef enum logic [1:0] {OA_D, OA_E1, OA_E2, OA_F} oa_vec_t;
  typedef enum logic [2:0] {OB_E1, OB_E2, OB_P, OB_QLO, OB_QHI} ob_vec_t;
  typedef enum logic [2:0] {DST_NONE, DST_P, DST_Q, DST_DET, DST_NU, DST_NV, DST_NT} dst_t;

  typedef struct packed {
    oa_vec_t    a_vec;
    logic [1:0] a_idx;
    ob_vec_t    b_vec;
    logic [1:0] b_idx;
    logic       sub;
    logic       sh;
    logic       first;
    dst_t       dst;
    logic [1:0] d_idx;
  } mc_t;

  function automatic mc_t mc_make(oa_vec_t av, logic [1:0] ai, ob_vec_t bv, logic [1:0] bi,
                                  logic sub, logic sh, logic first, dst_t dst,
                                  logic [1:0] di);
    mc_t m;
    m.a_vec = av;
    m.a_idx = ai;
    m.b_vec = bv;
    m.b_idx = bi;
    m.sub   = sub;
    m.sh    = sh;
    m.first = first;
    m.dst   = dst;
    m.d_idx = di;
    return m;
  endfunction

  // one multiply-accumulate per step
  function automatic mc_t mc_entry(logic [4:0] s);
    mc_t m;
    unique case (s)
      // P = (D x E2) >> 30
      5'd0:  m = mc_make(OA_D, 2'd1, OB_E2, 2'd2, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd1:  m = mc_make(OA_D, 2'd2, OB_E2, 2'd1, 1'b1, 1'b0, 1'b0, DST_P, 2'd0);
      5'd2:  m = mc_make(OA_D, 2'd2, OB_E2, 2'd0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd3:  m = mc_make(OA_D, 2'd0, OB_E2, 2'd2, 1'b1, 1'b0, 1'b0, DST_P, 2'd1);
      5'd4:  m = mc_make(OA_D, 2'd0, OB_E2, 2'd1, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd5:  m = mc_make(OA_D, 2'd1, OB_E2, 2'd0, 1'b1, 1'b0, 1'b0, DST_P, 2'd2);
      // det = E1 . P
      5'd6:  m = mc_make(OA_E1, 2'd0, OB_P, 2'd0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd7:  m = mc_make(OA_E1, 2'd1, OB_P, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd8:  m = mc_make(OA_E1, 2'd2, OB_P, 2'd2, 1'b0, 1'b0, 1'b0, DST_DET, 2'd0);
      // nu = F . P
      5'd9:  m = mc_make(OA_F, 2'd0, OB_P, 2'd0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd10: m = mc_make(OA_F, 2'd1, OB_P, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd11: m = mc_make(OA_F, 2'd2, OB_P, 2'd2, 1'b0, 1'b0, 1'b0, DST_NU, 2'd0);
      // Q = (F x E1) >> 16
      5'd12: m = mc_make(OA_F, 2'd1, OB_E1, 2'd2, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd13: m = mc_make(OA_F, 2'd2, OB_E1, 2'd1, 1'b1, 1'b0, 1'b0, DST_Q, 2'd0);
      5'd14: m = mc_make(OA_F, 2'd2, OB_E1, 2'd0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd15: m = mc_make(OA_F, 2'd0, OB_E1, 2'd2, 1'b1, 1'b0, 1'b0, DST_Q, 2'd1);
      5'd16: m = mc_make(OA_F, 2'd0, OB_E1, 2'd1, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd17: m = mc_make(OA_F, 2'd1, OB_E1, 2'd0, 1'b1, 1'b0, 1'b0, DST_Q, 2'd2);
      // nv = D . Q, each q in two halves
      5'd18: m = mc_make(OA_D, 2'd0, OB_QLO, 2'd0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd19: m = mc_make(OA_D, 2'd0, OB_QHI, 2'd0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      5'd20: m = mc_make(OA_D, 2'd1, OB_QLO, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd21: m = mc_make(OA_D, 2'd1, OB_QHI, 2'd1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      5'd22: m = mc_make(OA_D, 2'd2, OB_QLO, 2'd2, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd23: m = mc_make(OA_D, 2'd2, OB_QHI, 2'd2, 1'b0, 1'b1, 1'b0, DST_NV, 2'd0);
      // nt = E2 . Q
      5'd24: m = mc_make(OA_E2, 2'd0, OB_QLO, 2'd0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd25: m = mc_make(OA_E2, 2'd0, OB_QHI, 2'd0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      5'd26: m = mc_make(OA_E2, 2'd1, OB_QLO, 2'd1, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd27: m = mc_make(OA_E2, 2'd1, OB_QHI, 2'd1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
      5'd28: m = mc_make(OA_E2, 2'd2, OB_QLO, 2'd2, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd29: m = mc_make(OA_E2, 2'd2, OB_QHI, 2'd2, 1'b0, 1'b1, 1'b0, DST_NT, 2'd0);
      default: m = mc_make(OA_D, 2'd0, OB_E1, 2'd0, 1'b0, 1'b0, 1'b1, DST_NONE, 2'd0);
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/ray_triangle_closest_hit_unit.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_unit
// Closest front-facing ray/triangle hit over a stream of triangles.
// ----------------------------------------------------------------------------
// One ray is held in registers (origin Q16.16 at 0x00/0x04/0x08, unit
// direction Q1.30 at 0x0C/0x10/0x14). Each triangle word runs an exact
// Moller-Trumbore test: 30 multiply-accumulate steps through one shared
// 36x36 multiplier, each a multiply phase and an accumulate phase, an accept
// check, then for a hit three divisions (32, 17 and 17 bits) through one
// radix-2 divider, and an update of the nearest hit; a triangle marked last
// then emits its result word, after any wait for the output register to free
// up. in_stall is high while a triangle is in work. The nearest strictly
// closer hit is kept; a triangle marked last produces one result word and
// clears the hit state.
// The result sits in an output register, so the next triangle is taken
// while it waits.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_unit
  import rtch_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // triangle words
  input  logic              in_valid,
  output logic              in_stall,
  input  rtch_in_t          in_data,
  // result words
  output logic              out_valid,
  input  logic              out_stall,
  output rtch_out_t         out_data,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_CHECK, ST_DIV_T, ST_DIV_U, ST_DIV_V, ST_FINISH, ST_EMIT
  } state_t;

  localparam logic signed [CMP_W-1:0] CMP_ONE = CMP_W'(1);
  localparam logic [BARY_W-1:0]       ONE_Q16 = BARY_W'(65536);

  state_t state_r;
  logic [4:0] step_r;
  logic       phase_r;

  // ray
  logic signed [COORD_W-1:0] origin_r [3];
  logic signed [COORD_W-1:0] dir_r [3];

  // triangle in work
  logic signed [E_W-1:0] e1_r [3];
  logic signed [E_W-1:0] e2_r [3];
  logic signed [E_W-1:0] f_r [3];
  logic signed [P_W-1:0] p_r [3];
  logic signed [Q_W-1:0] q_r [3];
  logic signed [DET_W-1:0] det_r;
  logic signed [DET_W-1:0] nu_r;
  logic signed [ACC_W-1:0] nv_r;
  logic signed [ACC_W-1:0] nt_r;
  logic [TRIANGLE_ID_BITS-1:0] tri_id_r;
  logic [INSTANCE_ID_BITS-1:0] inst_id_r;
  logic                        last_r;
  logic                        hit_r;
  logic [DIST_W-1:0]           t_r;
  logic [BARY_W-1:0]           u_r;
  logic [BARY_W-1:0]           v_r;

  // nearest hit so far
  logic                        any_hit_r;
  logic [DIST_W-1:0]           best_dist_r;
  logic [TRIANGLE_ID_BITS-1:0] best_tri_r;
  logic [INSTANCE_ID_BITS-1:0] best_inst_r;
  logic [BARY_W-1:0]           best_u_r;
  logic [BARY_W-1:0]           best_v_r;

  rtch_out_t out_r;
  logic      out_valid_r;

  // datapath wiring
  mc_t                     mc;
  logic signed [MUL_W-1:0] d_ext [3];
  logic signed [MUL_W-1:0] e1_ext [3];
  logic signed [MUL_W-1:0] e2_ext [3];
  logic signed [MUL_W-1:0] f_ext [3];
  logic signed [MUL_W-1:0] p_ext [3];
  logic signed [MUL_W-1:0] qlo_ext [3];
  logic signed [MUL_W-1:0] qhi_ext [3];
  logic signed [MUL_W-1:0] a_set [3];
  logic signed [MUL_W-1:0] b_set [3];
  logic signed [MUL_W-1:0] op_a;
  logic signed [MUL_W-1:0] op_b;
  rtch_mac_ctl_t           mac_ctl;
  logic signed [ACC_W-1:0] mac_sum;
  logic                    mul_en;
  logic                    acc_en;

  logic signed [CMP_W-1:0] det_c, nu_c, nv_c, nt_c;
  logic                    reject;
  logic                    take;
  logic                    cfg_wr;

  logic              div_start;
  logic [DIV_W-1:0]  div_num;
  logic [DIV_W-1:0]  div_den;
  logic [ITER_W-1:0] div_iters;
  logic              div_done;
  logic [QUO_W-1:0]  div_quo;

  assign mc = mc_entry(step_r);

  // operand sets for the shared multiplier
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_ext[i]   = MUL_W'(dir_r[i]);
      e1_ext[i]  = MUL_W'(e1_r[i]);
      e2_ext[i]  = MUL_W'(e2_r[i]);
      f_ext[i]   = MUL_W'(f_r[i]);
      p_ext[i]   = MUL_W'(p_r[i]);
      qlo_ext[i] = MUL_W'({1'b0, q_r[i][QSPLIT-1:0]});
      qhi_ext[i] = MUL_W'($signed(q_r[i][Q_W-1:QSPLIT]));
    end
  end

  always_comb begin
    unique case (mc.a_vec)
      OA_D:  a_set = d_ext;
      OA_E1: a_set = e1_ext;
      OA_E2: a_set = e2_ext;
      OA_F:  a_set = f_ext;
    endcase
    case (mc.b_vec)
      OB_E1:   b_set = e1_ext;
      OB_E2:   b_set = e2_ext;
      OB_P:    b_set = p_ext;
      OB_QLO:  b_set = qlo_ext;
      default: b_set = qhi_ext;
    endcase
    case (mc.a_idx)
      2'd0:    op_a = a_set[0];
      2'd1:    op_a = a_set[1];
      default: op_a = a_set[2];
    endcase
    case (mc.b_idx)
      2'd0:    op_b = b_set[0];
      2'd1:    op_b = b_set[1];
      default: op_b = b_set[2];
    endcase
  end

  assign mac_ctl = '{sub: mc.sub, sh: mc.sh, first: mc.first};
  assign mul_en  = (state_r == ST_MAC) && !phase_r;
  assign acc_en  = (state_r == ST_MAC) && phase_r;

  rtch_mac u_mac (
    .clk    (clk),
    .mul_en (mul_en),
    .acc_en (acc_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .ctl    (mac_ctl),
    .sum    (mac_sum)
  );

  // front-facing, barycentric range and distance checks
  always_comb begin
    det_c  = CMP_W'(det_r);
    nu_c   = CMP_W'(nu_r);
    nv_c   = CMP_W'(nv_r);
    nt_c   = CMP_W'(nt_r);
    reject = (det_c <= CMP_ONE) || nu_c[CMP_W-1] || (nu_c > det_c) || nv_c[CMP_W-1] ||
             (((nu_c <<< 14) + nv_c) > (det_c <<< 14)) || ((nt_c <<< 16) <= det_c);
  end

  // divider requests: t after the checks, then u, then v
  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_W'($unsigned(nv_r)) << 2;
    div_den   = DIV_W'($unsigned(det_r)) << 16;
    div_iters = ITER_W'(17);
    unique case (state_r)
      ST_CHECK: begin
        div_start = !reject;
        div_num   = DIV_W'($unsigned(nt_r)) << 16;
        div_den   = DIV_W'($unsigned(det_r)) << 31;
        div_iters = ITER_W'(32);
      end
      ST_DIV_T: begin
        div_start = div_done;
        div_num   = DIV_W'($unsigned(nu_r)) << 16;
      end
      ST_DIV_U: begin
        div_start = div_done;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rtch_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den_sh (div_den),
    .iters  (div_iters),
    .done   (div_done),
    .quo    (div_quo)
  );

  assign take   = hit_r && (!any_hit_r || (t_r < best_dist_r));
  assign cfg_wr = psel && penable && pwrite;

  // register read
  always_comb begin
    case (paddr[4:2])
      REG_ORIGIN_X: prdata = origin_r[0];
      REG_ORIGIN_Y: prdata = origin_r[1];
      REG_ORIGIN_Z: prdata = origin_r[2];
      REG_DIR_X:    prdata = dir_r[0];
      REG_DIR_Y:    prdata = dir_r[1];
      REG_DIR_Z:    prdata = dir_r[2];
      default:      prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer, ray registers, hit state and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      phase_r     <= 1'b0;
      origin_r[0] <= '0;
      origin_r[1] <= '0;
      origin_r[2] <= '0;
      dir_r[0]    <= '0;
      dir_r[1]    <= '0;
      dir_r[2]    <= COORD_W'(32'sh4000_0000);
      any_hit_r   <= 1'b0;
      best_dist_r <= '1;
      best_tri_r  <= '0;
      best_inst_r <= '0;
      best_u_r    <= '0;
      best_v_r    <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration write
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_ORIGIN_X: origin_r[0] <= pwdata;
          REG_ORIGIN_Y: origin_r[1] <= pwdata;
          REG_ORIGIN_Z: origin_r[2] <= pwdata;
          REG_DIR_X:    dir_r[0]    <= pwdata;
          REG_DIR_Y:    dir_r[1]    <= pwdata;
          REG_DIR_Z:    dir_r[2]    <= pwdata;
          default:      ;
        endcase
      end

      // result word loaded on emit, dropped when taken
      if ((state_r == ST_EMIT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            e1_r[0]   <= E_W'(in_data.vertex_b_x) - E_W'(in_data.vertex_a_x);
            e1_r[1]   <= E_W'(in_data.vertex_b_y) - E_W'(in_data.vertex_a_y);
            e1_r[2]   <= E_W'(in_data.vertex_b_z) - E_W'(in_data.vertex_a_z);
            e2_r[0]   <= E_W'(in_data.vertex_c_x) - E_W'(in_data.vertex_a_x);
            e2_r[1]   <= E_W'(in_data.vertex_c_y) - E_W'(in_data.vertex_a_y);
            e2_r[2]   <= E_W'(in_data.vertex_c_z) - E_W'(in_data.vertex_a_z);
            f_r[0]    <= E_W'(origin_r[0]) - E_W'(in_data.vertex_a_x);
            f_r[1]    <= E_W'(origin_r[1]) - E_W'(in_data.vertex_a_y);
            f_r[2]    <= E_W'(origin_r[2]) - E_W'(in_data.vertex_a_z);
            tri_id_r  <= in_data.triangle_id;
            inst_id_r <= in_data.instance_id;
            last_r    <= in_data.last_triangle;
            hit_r     <= 1'b0;
            step_r    <= '0;
            phase_r   <= 1'b0;
            state_r   <= ST_MAC;
          end
        end

        ST_MAC: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else begin
            // store the finished sum
            case (mc.dst)
              DST_P:   p_r[mc.d_idx] <= mac_sum[P_W+29:30];
              DST_Q:   q_r[mc.d_idx] <= mac_sum[Q_W+15:16];
              DST_DET: det_r <= mac_sum[DET_W-1:0];
              DST_NU:  nu_r <= mac_sum[DET_W-1:0];
              DST_NV:  nv_r <= mac_sum;
              DST_NT:  nt_r <= mac_sum;
              default: ;
            endcase
            phase_r <= 1'b0;
            if (step_r == MC_LAST) begin
              state_r <= ST_CHECK;
            end else begin
              step_r <= step_r + 5'd1;
            end
          end
        end

        ST_CHECK: begin
          state_r <= reject ? ST_FINISH : ST_DIV_T;
        end

        ST_DIV_T: begin
          if (div_done) begin
            t_r     <= div_quo[QUO_W-1] ? '1 : div_quo[DIST_W-1:0];
            state_r <= ST_DIV_U;
          end
        end

        ST_DIV_U: begin
          if (div_done) begin
            u_r     <= div_quo[BARY_W-1:0];
            state_r <= ST_DIV_V;
          end
        end

        ST_DIV_V: begin
          if (div_done) begin
            v_r     <= div_quo[BARY_W-1:0];
            hit_r   <= 1'b1;
            state_r <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (take) begin
            any_hit_r   <= 1'b1;
            best_dist_r <= t_r;
            best_tri_r  <= tri_id_r;
            best_inst_r <= inst_id_r;
            best_u_r    <= u_r;
            best_v_r    <= v_r;
          end
          state_r <= last_r ? ST_EMIT : ST_IDLE;
        end

        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_r.hit          <= any_hit_r;
            out_r.hit_instance <= any_hit_r ? best_inst_r : '0;
            out_r.hit_triangle <= any_hit_r ? best_tri_r : '0;
            out_r.distance     <= any_hit_r ? best_dist_r : '0;
            out_r.bary_w       <= any_hit_r ? (ONE_Q16 - best_u_r - best_v_r) : '0;
            out_r.bary_u       <= any_hit_r ? best_u_r : '0;
            out_r.bary_v       <= any_hit_r ? best_v_r : '0;
            any_hit_r          <= 1'b0;
            best_dist_r        <= '1;
            best_tri_r         <= '0;
            best_inst_r        <= '0;
            best_u_r           <= '0;
            best_v_r           <= '0;
            state_r            <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/rtch_mac.sv =====
// ----------------------------------------------------------------------------
// rtch_mac
// Shared signed multiplier with a registered product and a wide accumulator.
// ----------------------------------------------------------------------------
module rtch_mac
  import rtch_pkg::*;
(
  input  logic                     clk,
  input  logic                     mul_en,
  input  logic                     acc_en,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  input  rtch_mac_ctl_t            ctl,
  output logic signed [ACC_W-1:0]  sum
);

  logic signed [PROD_W-1:0] prod_r;
  rtch_mac_ctl_t            ctl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base;

  // product stage
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= op_a * op_b;
      ctl_r  <= ctl;
    end
  end

  // shifted add or subtract into the accumulator
  always_comb begin
    term = ACC_W'(prod_r);
    if (ctl_r.sh) begin
      term = term <<< QSPLIT;
    end
    base = ctl_r.first ? '0 : acc_r;
    sum  = ctl_r.sub ? (base - term) : (base + term);
  end

  always_ff @(posedge clk) begin
    if (acc_en) begin
      acc_r <= sum;
    end
  end

endmodule

// ===== hw/rtl/rtch_div.sv =====
// ----------------------------------------------------------------------------
// rtch_div
// Radix-2 restoring divider, one quotient bit per cycle, with a
// pre-aligned divisor supplied by the caller.
// ----------------------------------------------------------------------------
module rtch_div
  import rtch_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  num,
  input  logic [DIV_W-1:0]  den_sh,
  input  logic [ITER_W-1:0] iters,
  output logic              done,
  output logic [QUO_W-1:0]  quo
);

  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dsh_r;
  logic [QUO_W-1:0]  quo_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;

  assign ge   = (rem_r >= dsh_r);
  assign done = done_r;
  assign quo  = quo_r;

  // iterate: compare, subtract, shift divisor down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= num;
        dsh_r  <= den_sh;
        cnt_r  <= iters;
        quo_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        quo_r <= {quo_r[QUO_W-2:0], ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - ITER_W'(1);
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
